[src/cpfp_pkg.sv]
// shared types and constants of the cell parameter field parser
package cpfp_pkg;

   // character classes decided by the front end
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_OTHER      = 3'd0;
   localparam kind_type KIND_UNDERSCORE = 3'd1;
   localparam kind_type KIND_POINT      = 3'd2;
   localparam kind_type KIND_DIGIT      = 3'd3;
   localparam kind_type KIND_EOT        = 3'd4;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_POINT      = 8'h2E;
   localparam logic [7:0] CHAR_ZERO       = 8'd48;
   localparam logic [7:0] CHAR_NINE       = 8'd57;

   // one classified request as it sits in the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_code;
      logic [3:0] digit;
   } entry_type;

endpackage

[src/cpfp_front.sv]
// front end: takes text requests and classifies each byte
module cpfp_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_ready,
   output logic               q_push,
   output cpfp_pkg::entry_type q_entry
);
   import cpfp_pkg::*;

   logic [7:0] digit_diff;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;
   assign digit_diff = req_tdata - CHAR_ZERO;

   always_comb begin
      q_entry.char_code = req_tdata;
      q_entry.digit     = digit_diff[3:0];
      if (req_tlast) begin
         q_entry.kind = KIND_EOT;
      end else if (req_tdata == CHAR_UNDERSCORE) begin
         q_entry.kind = KIND_UNDERSCORE;
      end else if (req_tdata == CHAR_POINT) begin
         q_entry.kind = KIND_POINT;
      end else if (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE) begin
         q_entry.kind = KIND_DIGIT;
      end else begin
         q_entry.kind = KIND_OTHER;
      end
   end

endmodule

[src/cpfp_queue.sv]
// two-entry queue between the front end and the parser
module cpfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpfp_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output cpfp_pkg::entry_type pop_entry
);
   import cpfp_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/cpfp_back.sv]
// back end: keyword matcher, number scanner and result register
module cpfp_back #(
   parameter int FRACTION_DIGITS = 4,
   parameter int VALUE_BITS      = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cpfp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic [4:0]          rsp_tuser
);
   import cpfp_pkg::*;

   localparam int FC_W  = $clog2(FRACTION_DIGITS + 1);
   localparam int SUM_W = VALUE_BITS + 5;
   localparam int TERM_W = 24;

   localparam logic [3:0] PH_WAIT    = 4'd0;
   localparam logic [3:0] PH_NEWCMD  = 4'd1;
   localparam logic [3:0] PH_CELL    = 4'd2;
   localparam logic [3:0] PH_CLEN    = 4'd3;
   localparam logic [3:0] PH_CANG    = 4'd4;
   localparam logic [3:0] PH_M_ELL   = 4'd5;
   localparam logic [3:0] PH_M_ENGTH = 4'd6;
   localparam logic [3:0] PH_M_NGLE  = 4'd7;
   localparam logic [3:0] PH_M_ANGW  = 4'd8;
   localparam logic [3:0] PH_S_CELL  = 4'd9;
   localparam logic [3:0] PH_S_LEN   = 4'd10;
   localparam logic [3:0] PH_S_ANG   = 4'd11;
   localparam logic [3:0] PH_NUMBER  = 4'd12;
   localparam logic [3:0] PH_END     = 4'd13;

   localparam logic [2:0] W_ELL   = 3'd0;
   localparam logic [2:0] W_ENGTH = 3'd1;
   localparam logic [2:0] W_NGLE  = 3'd2;
   localparam logic [2:0] W_ALPHA = 3'd3;
   localparam logic [2:0] W_BETA  = 3'd4;
   localparam logic [2:0] W_GAMMA = 3'd5;

   localparam logic [2:0] P_A     = 3'd0;
   localparam logic [2:0] P_B     = 3'd1;
   localparam logic [2:0] P_C     = 3'd2;
   localparam logic [2:0] P_ALPHA = 3'd3;
   localparam logic [2:0] P_BETA  = 3'd4;
   localparam logic [2:0] P_GAMMA = 3'd5;

   localparam logic [7:0] CH_A = "a";
   localparam logic [7:0] CH_B = "b";
   localparam logic [7:0] CH_C = "c";
   localparam logic [7:0] CH_E = "e";
   localparam logic [7:0] CH_G = "g";
   localparam logic [7:0] CH_H = "h";
   localparam logic [7:0] CH_L = "l";
   localparam logic [7:0] CH_M = "m";
   localparam logic [7:0] CH_N = "n";
   localparam logic [7:0] CH_P = "p";
   localparam logic [7:0] CH_T = "t";

   function automatic logic [2:0] word_len(input logic [2:0] w);
      case (w)
         W_ELL:   word_len = 3'd3;
         W_ENGTH: word_len = 3'd5;
         W_NGLE:  word_len = 3'd4;
         W_ALPHA: word_len = 3'd4;
         W_BETA:  word_len = 3'd3;
         W_GAMMA: word_len = 3'd4;
         default: word_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'd0;
      case (w)
         W_ELL: begin
            case (pos)
               3'd0:    c = CH_E;
               3'd1:    c = CH_L;
               3'd2:    c = CH_L;
               default: c = 8'd0;
            endcase
         end
         W_ENGTH: begin
            case (pos)
               3'd0:    c = CH_E;
               3'd1:    c = CH_N;
               3'd2:    c = CH_G;
               3'd3:    c = CH_T;
               3'd4:    c = CH_H;
               default: c = 8'd0;
            endcase
         end
         W_NGLE: begin
            case (pos)
               3'd0:    c = CH_N;
               3'd1:    c = CH_G;
               3'd2:    c = CH_L;
               3'd3:    c = CH_E;
               default: c = 8'd0;
            endcase
         end
         W_ALPHA: begin
            case (pos)
               3'd0:    c = CH_L;
               3'd1:    c = CH_P;
               3'd2:    c = CH_H;
               3'd3:    c = CH_A;
               default: c = 8'd0;
            endcase
         end
         W_BETA: begin
            case (pos)
               3'd0:    c = CH_E;
               3'd1:    c = CH_T;
               3'd2:    c = CH_A;
               default: c = 8'd0;
            endcase
         end
         W_GAMMA: begin
            case (pos)
               3'd0:    c = CH_A;
               3'd1:    c = CH_M;
               3'd2:    c = CH_M;
               3'd3:    c = CH_A;
               default: c = 8'd0;
            endcase
         end
         default: c = 8'd0;
      endcase
      word_char = c;
   endfunction

   function automatic logic [19:0] pow10(input logic [2:0] n);
      case (n)
         3'd0:    pow10 = 20'd1;
         3'd1:    pow10 = 20'd10;
         3'd2:    pow10 = 20'd100;
         3'd3:    pow10 = 20'd1000;
         3'd4:    pow10 = 20'd10000;
         3'd5:    pow10 = 20'd100000;
         3'd6:    pow10 = 20'd1000000;
         default: pow10 = 20'd0;
      endcase
   endfunction

   logic [3:0]            phase_ff, phase_in;
   logic [2:0]            match_pos_ff, match_pos_in;
   logic [2:0]            target_ff, target_in;
   logic [VALUE_BITS-1:0] accum_ff, accum_in;
   logic [FC_W-1:0]       frac_cnt_ff, frac_cnt_in;
   logic                  point_ff, point_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic                  ovf_ff, ovf_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff;
   logic [4:0]            rsp_user_ff;

   logic                  out_free;
   logic                  emit;
   logic                  is_us;
   logic [7:0]            ch;
   logic [2:0]            word_sel;
   logic [3:0]            phase_off;
   logic [2:0]            match_next;
   logic                  bad_target;
   logic [2:0]            pow_sel;
   logic [TERM_W-1:0]     term;
   logic [SUM_W-1:0]      accum_ext;
   logic [SUM_W-1:0]      int_sum;
   logic [SUM_W-1:0]      frac_sum;
   logic                  int_over;
   logic                  frac_over;
   logic [VALUE_BITS+31:0] accum_wide;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = q_valid && out_free;
   assign ch       = q_entry.char_code;
   assign is_us    = (q_entry.kind == KIND_UNDERSCORE);

   assign phase_off  = phase_ff - PH_M_ELL;
   assign word_sel   = (phase_ff == PH_M_ANGW) ? target_ff : phase_off[2:0];
   assign bad_target = (phase_ff == PH_M_ANGW) && (target_ff < P_ALPHA || target_ff > P_GAMMA);
   assign match_next = match_pos_ff + 3'd1;

   // integer digits weigh 10^F, fraction digits 10^(F-1-count)
   assign pow_sel = point_ff ? (3'(FRACTION_DIGITS - 1) - 3'(frac_cnt_ff))
                             : 3'(FRACTION_DIGITS);
   assign term      = TERM_W'(q_entry.digit * pow10(pow_sel));
   assign accum_ext = SUM_W'(accum_ff);
   assign int_sum   = (accum_ext << 3) + (accum_ext << 1) + SUM_W'(term);
   assign frac_sum  = accum_ext + SUM_W'(term);
   assign int_over  = ovf_ff || (|int_sum[SUM_W-1:VALUE_BITS]);
   assign frac_over = ovf_ff || (|frac_sum[SUM_W-1:VALUE_BITS]);
   assign accum_wide = {32'd0, accum_ff};

   always_comb begin
      phase_in      = phase_ff;
      match_pos_in  = match_pos_ff;
      target_in     = target_ff;
      accum_in      = accum_ff;
      frac_cnt_in   = frac_cnt_ff;
      point_in      = point_ff;
      digit_seen_in = digit_seen_ff;
      ovf_in        = ovf_ff;
      emit          = 1'b0;

      if (q_pop && phase_ff != PH_END) begin
         if (q_entry.kind == KIND_EOT) begin
            phase_in = PH_END;
            emit     = (phase_ff == PH_NUMBER);
         end else begin
            unique case (phase_ff) inside
               PH_NEWCMD: begin
                  if (ch == CH_C) begin
                     phase_in     = PH_M_ELL;
                     match_pos_in = 3'd0;
                  end else if (is_us) begin
                     phase_in = PH_NEWCMD;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_CELL: begin
                  if (ch == CH_L) begin
                     phase_in     = PH_M_ENGTH;
                     match_pos_in = 3'd0;
                  end else if (ch == CH_A) begin
                     phase_in     = PH_M_NGLE;
                     match_pos_in = 3'd0;
                  end else if (is_us) begin
                     phase_in = PH_NEWCMD;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_CLEN: begin
                  if (ch == CH_A || ch == CH_B || ch == CH_C) begin
                     phase_in      = PH_NUMBER;
                     target_in     = (ch == CH_A) ? P_A : ((ch == CH_B) ? P_B : P_C);
                     accum_in      = '0;
                     frac_cnt_in   = '0;
                     point_in      = 1'b0;
                     digit_seen_in = 1'b0;
                     ovf_in        = 1'b0;
                  end else if (is_us) begin
                     phase_in = PH_NEWCMD;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_CANG: begin
                  if (ch == CH_A || ch == CH_B || ch == CH_G) begin
                     phase_in     = PH_M_ANGW;
                     target_in    = (ch == CH_A) ? P_ALPHA : ((ch == CH_B) ? P_BETA : P_GAMMA);
                     match_pos_in = 3'd0;
                  end else if (is_us) begin
                     phase_in = PH_NEWCMD;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_M_ELL, PH_M_ENGTH, PH_M_NGLE, PH_M_ANGW: begin
                  if (bad_target) begin
                     phase_in = PH_WAIT;
                  end else if (is_us) begin
                     phase_in = PH_NEWCMD;
                  end else if (match_pos_ff >= word_len(word_sel)
                               || ch != word_char(word_sel, match_pos_ff)) begin
                     phase_in = PH_WAIT;
                  end else begin
                     match_pos_in = match_next;
                     if (match_next == word_len(word_sel)) begin
                        if (phase_ff == PH_M_ELL) begin
                           phase_in = PH_S_CELL;
                        end else if (phase_ff == PH_M_ENGTH) begin
                           phase_in = PH_S_LEN;
                        end else if (phase_ff == PH_M_NGLE) begin
                           phase_in = PH_S_ANG;
                        end else begin
                           phase_in      = PH_NUMBER;
                           accum_in      = '0;
                           frac_cnt_in   = '0;
                           point_in      = 1'b0;
                           digit_seen_in = 1'b0;
                           ovf_in        = 1'b0;
                        end
                     end
                  end
               end
               PH_S_CELL: begin
                  if (is_us) begin
                     phase_in = PH_CELL;
                  end
               end
               PH_S_LEN: begin
                  if (is_us) begin
                     phase_in = PH_CLEN;
                  end
               end
               PH_S_ANG: begin
                  if (is_us) begin
                     phase_in = PH_CANG;
                  end
               end
               PH_NUMBER: begin
                  if (is_us) begin
                     phase_in = PH_NEWCMD;
                     emit     = 1'b1;
                  end else if (q_entry.kind == KIND_POINT) begin
                     if (point_ff) begin
                        phase_in = PH_WAIT;
                        emit     = 1'b1;
                     end else begin
                        point_in = 1'b1;
                     end
                  end else if (q_entry.kind == KIND_DIGIT) begin
                     digit_seen_in = 1'b1;
                     if (!point_ff) begin
                        // shift up one decade and add, clamp on overflow
                        if (int_over) begin
                           accum_in = '1;
                           ovf_in   = 1'b1;
                        end else begin
                           accum_in = int_sum[VALUE_BITS-1:0];
                        end
                     end else if (frac_cnt_ff < FC_W'(FRACTION_DIGITS)) begin
                        frac_cnt_in = frac_cnt_ff + FC_W'(1);
                        if (frac_over) begin
                           accum_in = '1;
                           ovf_in   = 1'b1;
                        end else begin
                           accum_in = frac_sum[VALUE_BITS-1:0];
                        end
                     end
                  end else if (digit_seen_ff) begin
                     phase_in = PH_WAIT;
                     emit     = 1'b1;
                  end
               end
               default: begin
                  phase_in = is_us ? PH_NEWCMD : PH_WAIT;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = q_pop && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         match_pos_ff  <= 3'd0;
         target_ff     <= 3'd0;
         accum_ff      <= '0;
         frac_cnt_ff   <= '0;
         point_ff      <= 1'b0;
         digit_seen_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         match_pos_ff  <= match_pos_in;
         target_ff     <= target_in;
         accum_ff      <= accum_in;
         frac_cnt_ff   <= frac_cnt_in;
         point_ff      <= point_in;
         digit_seen_ff <= digit_seen_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // results always report the state before this byte
   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_data_ff <= accum_wide[31:0];
         rsp_user_ff <= {ovf_ff, digit_seen_ff, target_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[src/cell_parameter_field_parser_top.sv]
// top level of the cell parameter field parser
//
// usage: text bytes enter one per request on the req_ channel; req_tlast
// marks end of file (its data byte is ignored). keyword paths _cell_length
// then a/b/c and _cell_angle then alpha/beta/gamma start a decimal scan,
// and the end of each scan produces one request on the rsp_ channel with
// the parameter index, the value times 10^FRACTION_DIGITS (clamped, with
// a saturated flag) and whether any digit was seen.
// throughput: one byte per cycle while no result waits on rsp_; each parser
// step does one multiply by ten and add on the accumulator.
// a byte that ends a scan is registered in the queue first; when the parser
// pops it, its result is taken by the result register and shown on rsp_.
// reset: the parser waits for an underscore, the queue and the result
// register are empty. after end of file every byte is dropped until reset.
// stall: a result holds on rsp_ while rsp_tready is low; bytes keep being
// taken until the two-entry queue fills, then req_tready drops.
module cell_parameter_field_parser_top #(
   parameter int FRACTION_DIGITS = 4,
   parameter int VALUE_BITS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code[7:0]
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value_e4[31:0]
   output logic [4:0]  rsp_tuser    // param_index[2:0], had_digit[3], saturated[4]
);
   import cpfp_pkg::*;

   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      push_ready;
   logic      pop;
   logic      pop_valid;

   cpfp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (push_ready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   cpfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   cpfp_back #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .VALUE_BITS      (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sim/cell_parameter_field_parser_top_tb.sv]
// random and directed testbench of the cell parameter field parser
module cell_parameter_field_parser_top_tb;
   import cpfp_pkg::*;

   localparam int          FRAC_DIGITS   = 4;
   localparam logic [63:0] VALUE_MAX     = 64'hFFFF_FFFF;
   localparam int          RANDOM_ITEMS  = 500;
   localparam int          LONG_HOLD     = 400;
   localparam int          STALL_LIMIT   = 3000;

   typedef enum logic [3:0] {
      P_SKIP, P_CMD, P_AFTER_CELL, P_AFTER_LEN, P_AFTER_ANG,
      P_WORD_ELL, P_WORD_ENGTH, P_WORD_NGLE, P_WORD_AXIS,
      P_REST_CELL, P_REST_LEN, P_REST_ANG, P_NUMBER, P_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]  param;
      logic [31:0] value;
      logic        had_digit;
      logic        saturated;
   } cell_reading_type;

   class cell_field_tracker_type;
      parse_phase_type  phase;
      int               word_pos;
      logic [2:0]       param;
      logic [63:0]      accum;
      int               frac_count;
      bit               point_seen;
      bit               digit_seen;
      bit               clamped;
      string            words[6];
      cell_reading_type readings[$];
      int               errors;

      function new();
         phase      = P_SKIP;
         word_pos   = 0;
         param      = '0;
         accum      = '0;
         frac_count = 0;
         point_seen = 0;
         digit_seen = 0;
         clamped    = 0;
         errors     = 0;
         words[0]   = "ell";
         words[1]   = "ength";
         words[2]   = "ngle";
         words[3]   = "lpha";
         words[4]   = "eta";
         words[5]   = "amma";
      endfunction

      function logic [63:0] pow10(int n);
         logic [63:0] v;
         v = 64'd1;
         repeat (n) v = v * 64'd10;
         return v;
      endfunction

      function void begin_number(logic [2:0] p);
         phase      = P_NUMBER;
         param      = p;
         accum      = '0;
         frac_count = 0;
         point_seen = 0;
         digit_seen = 0;
         clamped    = 0;
      endfunction

      function void add_clamped(logic [63:0] amount);
         if (clamped || accum > VALUE_MAX || amount > VALUE_MAX - accum) begin
            accum   = VALUE_MAX;
            clamped = 1;
         end else begin
            accum = accum + amount;
         end
      endfunction

      function void take_digit(logic [3:0] d);
         digit_seen = 1;
         if (!point_seen) begin
            if (clamped || accum > VALUE_MAX / 10) begin
               accum   = VALUE_MAX;
               clamped = 1;
            end else begin
               accum = accum * 64'd10;
            end
            add_clamped(64'(d) * pow10(FRAC_DIGITS));
         end else if (frac_count < FRAC_DIGITS) begin
            add_clamped(64'(d) * pow10(FRAC_DIGITS - 1 - frac_count));
            frac_count++;
         end
      endfunction

      function void push_reading();
         cell_reading_type r;
         r.param     = param;
         r.value     = accum[31:0];
         r.had_digit = digit_seen;
         r.saturated = clamped;
         readings.push_back(r);
      endfunction

      // one parser step per accepted request
      function void note_request(logic [7:0] ch, logic eot);
         int w;
         if (phase == P_DONE) return;
         if (eot) begin
            if (phase == P_NUMBER) push_reading();
            phase = P_DONE;
            return;
         end
         case (phase)
            P_CMD:
               if (ch == "c") begin
                  phase    = P_WORD_ELL;
                  word_pos = 0;
               end else if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else phase = P_SKIP;
            P_AFTER_CELL:
               if (ch == "l") begin
                  phase    = P_WORD_ENGTH;
                  word_pos = 0;
               end else if (ch == "a") begin
                  phase    = P_WORD_NGLE;
                  word_pos = 0;
               end else if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else phase = P_SKIP;
            P_AFTER_LEN:
               if (ch == "a") begin_number(3'd0);
               else if (ch == "b") begin_number(3'd1);
               else if (ch == "c") begin_number(3'd2);
               else if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else phase = P_SKIP;
            P_AFTER_ANG: begin
               word_pos = 0;
               if (ch == "a") begin
                  phase = P_WORD_AXIS;
                  param = 3'd3;
               end else if (ch == "b") begin
                  phase = P_WORD_AXIS;
                  param = 3'd4;
               end else if (ch == "g") begin
                  phase = P_WORD_AXIS;
                  param = 3'd5;
               end else if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else phase = P_SKIP;
            end
            P_WORD_ELL, P_WORD_ENGTH, P_WORD_NGLE, P_WORD_AXIS: begin
               case (phase)
                  P_WORD_ELL:   w = 0;
                  P_WORD_ENGTH: w = 1;
                  P_WORD_NGLE:  w = 2;
                  default:      w = int'(param);
               endcase
               if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else if (ch != 8'(words[w][word_pos])) phase = P_SKIP;
               else begin
                  word_pos++;
                  if (word_pos == words[w].len()) begin
                     case (phase)
                        P_WORD_ELL:   phase = P_REST_CELL;
                        P_WORD_ENGTH: phase = P_REST_LEN;
                        P_WORD_NGLE:  phase = P_REST_ANG;
                        default:      begin_number(param);
                     endcase
                  end
               end
            end
            // rest of the keyword is skipped up to the next underscore
            P_REST_CELL: if (ch == CHAR_UNDERSCORE) phase = P_AFTER_CELL;
            P_REST_LEN:  if (ch == CHAR_UNDERSCORE) phase = P_AFTER_LEN;
            P_REST_ANG:  if (ch == CHAR_UNDERSCORE) phase = P_AFTER_ANG;
            P_NUMBER:
               if (ch == CHAR_UNDERSCORE) begin
                  phase = P_CMD;
                  push_reading();
               end else if (ch == CHAR_POINT) begin
                  if (point_seen) begin
                     phase = P_SKIP;
                     push_reading();
                  end else begin
                     point_seen = 1;
                  end
               end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  take_digit(4'(ch - CHAR_ZERO));
               end else if (digit_seen) begin
                  phase = P_SKIP;
                  push_reading();
               end
            default:
               if (ch == CHAR_UNDERSCORE) phase = P_CMD;
               else phase = P_SKIP;
         endcase
      endfunction

      function void check_response(logic [31:0] data, logic [4:0] user);
         cell_reading_type want;
         if (readings.size() == 0) begin
            $display("%0t: unexpected result param_index %0d value_e4 %0d", $time,
                     user[2:0], data);
            errors++;
            return;
         end
         want = readings.pop_front();
         if (user[2:0] != want.param) begin
            $display("%0t: param_index expected %0d got %0d", $time, want.param, user[2:0]);
            errors++;
         end
         if (data != want.value) begin
            $display("%0t: value_e4 expected %0d got %0d", $time, want.value, data);
            errors++;
         end
         if (user[3] != want.had_digit) begin
            $display("%0t: had_digit expected %0d got %0d", $time, want.had_digit, user[3]);
            errors++;
         end
         if (user[4] != want.saturated) begin
            $display("%0t: saturated expected %0d got %0d", $time, want.saturated, user[4]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;

   cell_field_tracker_type tracker = new();
   logic [7:0]             text_q[$];
   int                     items_sent  = 0;
   int                     burst_left  = 0;
   int                     idle_cycles = 0;
   bit                     long_hold_req = 0;

   cell_parameter_field_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) tracker.note_request(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side pacing, with one long hold on request
   always begin : rsp_pacer
      int n;
      @(posedge clock);
      if (long_hold_req) begin
         rsp_tready <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
         long_hold_req = 0;
      end else begin
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic eot);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic flush_text();
      while (text_q.size() > 0) send_item(text_q.pop_front(), 1'b0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.readings.size() != 0) @(posedge clock);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
   endtask

   // never a digit, a point or an underscore
   function automatic logic [7:0] filler_char();
      string pool;
      pool = " \t=:x(#";
      return 8'(pool[$urandom_range(0, pool.len() - 1)]);
   endfunction

   task automatic add_number();
      int int_len;
      int frac_len;
      repeat ($urandom_range(0, 2)) text_q.push_back(filler_char());
      int_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      repeat (int_len) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
         text_q.push_back(CHAR_POINT);
         frac_len = $urandom_range(0, 7);
         repeat (frac_len) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      case ($urandom_range(0, 5))
         0, 1:    add_str(" ");
         2:       add_str("\n");
         3:       text_q.push_back(CHAR_UNDERSCORE);
         4:       text_q.push_back(CHAR_POINT);
         default: ;
      endcase
   endtask

   task automatic add_record();
      add_str("_cell");
      if ($urandom_range(0, 7) == 0) text_q.push_back(filler_char());
      if ($urandom_range(0, 1) == 0) begin
         add_str("_length");
         if ($urandom_range(0, 7) == 0) text_q.push_back(filler_char());
         case ($urandom_range(0, 2))
            0:       add_str("_a");
            1:       add_str("_b");
            default: add_str("_c");
         endcase
      end else begin
         add_str("_angle");
         if ($urandom_range(0, 7) == 0) text_q.push_back(filler_char());
         case ($urandom_range(0, 2))
            0:       add_str("_alpha");
            1:       add_str("_beta");
            default: add_str("_gamma");
         endcase
      end
      add_number();
   endtask

   task automatic add_broken();
      int first;
      int spot;
      first = text_q.size();
      add_record();
      spot = $urandom_range(first, text_q.size() - 1);
      case ($urandom_range(0, 3))
         0:       text_q[spot] = 8'($urandom_range(0, 255));
         1:       text_q.delete(spot);
         2:       text_q.insert(spot, CHAR_UNDERSCORE);
         default: while (text_q.size() > spot) void'(text_q.pop_back());
      endcase
   endtask

   task automatic add_noise();
      case ($urandom_range(0, 3))
         0:       add_str("_symmetry_space_group_name 'P 1'\n");
         1:       add_str("_atom_site_fract_x 0.25\n");
         default: repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin : stimulus
      int  r;
      int  stop_at;
      bit  held;
      bit  paused;
      held   = 0;
      paused = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_str("_cell_length_a 0 ");
      add_str("_cell_length_b 429496.7295\n");   // largest value that fits
      add_str("_cell_length_c 429496.7296 ");    // one past it clamps
      add_str("_cell_angle_alpha 90.123456 ");   // extra fraction digits dropped
      add_str("_cell_angle_beta ?_");            // scan without digits
      add_str("_cell_angle_gamma =.5.7");        // leading point, second point ends scan
      add_str("_ce_cell_length_a 12345678901 "); // underscore mid keyword, integer overflow
      add_str("_symmetry_equiv_pos_as_xyz x_atom_site_label C1 ");
      add_str("_cellX_lengthY_b 7");
      flush_text();
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);

      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if (!held && items_sent > stop_at - 450) begin
            // results back up while the sender keeps going
            long_hold_req = 1;
            repeat (8) add_record();
            flush_text();
            held = 1;
         end
         if (!paused && items_sent > stop_at - 200) begin
            wait_drained();
            paused = 1;
         end
         r = $urandom_range(0, 99);
         if (r < 70) add_record();
         else if (r < 85) add_broken();
         else add_noise();
         flush_text();
      end

      // end of file in the middle of a scan, then requests that are dropped
      add_str("_cell_angle_gamma 120.5");
      flush_text();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      repeat (5) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      add_str("_cell_length_a 3 ");
      flush_text();

      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.readings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[sim.f]
src/cpfp_pkg.sv
src/cpfp_front.sv
src/cpfp_queue.sv
src/cpfp_back.sv
src/cell_parameter_field_parser_top.sv
sim/cell_parameter_field_parser_top_tb.sv
